@@ hw/rtl/mpd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mpd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;

    localparam logic [CFG_INDEX_W-1:0] REG_HALF_BIT_TIME = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MSB_FIRST     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_BIT     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_ALIGNED = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_BYTES     = 3'd4;

    localparam logic [14:0] HALF_BIT_TIME_RESET = 15'd500;
    localparam logic        MSB_FIRST_RESET     = 1'b1;
    localparam logic        FIRST_BIT_RESET     = 1'b0;
    localparam logic        CLOCK_ALIGNED_RESET = 1'b0;
    localparam logic [7:0]  MAX_BYTES_RESET     = 8'd8;

    localparam logic       KIND_DATA    = 1'b0;
    localparam logic       KIND_SUMMARY = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ALIGN = 2'd2;

    typedef struct packed {
        logic [14:0] half_bit_time;
        logic        msb_first;
        logic        first_bit;
        logic        clock_aligned;
        logic [7:0]  max_bytes;
    } cfg_t;

    typedef struct packed {
        logic [15:0] pulse_length;
        logic        last_pulse;
    } in_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  data_byte;
        logic [3:0]  bits_in_byte;
        logic [10:0] total_bits;
        logic [15:0] pulses_used;
        logic [1:0]  status;
    } out_t;

endpackage

`default_nettype wire

@@ hw/rtl/mpd_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mpd_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [mpd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [mpd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output mpd_pkg::cfg_t                          cfg
);

    mpd_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_bit_time <= mpd_pkg::HALF_BIT_TIME_RESET;
            cfg_reg.msb_first     <= mpd_pkg::MSB_FIRST_RESET;
            cfg_reg.first_bit     <= mpd_pkg::FIRST_BIT_RESET;
            cfg_reg.clock_aligned <= mpd_pkg::CLOCK_ALIGNED_RESET;
            cfg_reg.max_bytes     <= mpd_pkg::MAX_BYTES_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mpd_pkg::REG_HALF_BIT_TIME: cfg_reg.half_bit_time <= cfg_data[14:0];
                mpd_pkg::REG_MSB_FIRST:     cfg_reg.msb_first     <= cfg_data[0];
                mpd_pkg::REG_FIRST_BIT:     cfg_reg.first_bit     <= cfg_data[0];
                mpd_pkg::REG_CLOCK_ALIGNED: cfg_reg.clock_aligned <= cfg_data[0];
                mpd_pkg::REG_MAX_BYTES:     cfg_reg.max_bytes     <= cfg_data[7:0];
                default:                    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ hw/rtl/mpd_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mpd_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mpd_pkg::cfg_t cfg,
    input  wire logic          fire,
    input  wire mpd_pkg::in_t  beat,
    output logic               has_result,
    output mpd_pkg::out_t      result
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_DATA  = 2'd1;
    localparam logic [1:0] PH_PAIR  = 2'd2;
    localparam logic [1:0] PH_DRAIN = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic        current_bit_reg, current_bit_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [2:0]  bit_count_reg, bit_count_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [15:0] pulse_count_reg, pulse_count_next;

    logic [15:0] smin;
    logic [15:0] sep;
    logic [16:0] lmax;
    logic        p_below_min;
    logic        p_below_sep;
    logic        p_above_sep;
    logic        p_above_max;
    logic        pair_ok;
    logic        last;

    logic        run_data;
    logic        run_group;
    logic        fin;
    logic [1:0]  fin_status;
    logic [7:0]  pushed;
    logic [16:0] pulse_sum;

    function automatic logic [7:0] push_bit(input logic [7:0] b, input logic v,
                                            input logic msb);
        push_bit = msb ? {b[6:0], v} : {v, b[7:1]};
    endfunction

    assign smin = {2'b00, cfg.half_bit_time[14:1]};
    assign sep  = {1'b0, cfg.half_bit_time} + smin;
    assign lmax = {1'b0, sep} + {2'b00, cfg.half_bit_time};
    assign last = beat.last_pulse;

    assign p_below_min = beat.pulse_length < smin;
    assign p_below_sep = beat.pulse_length < sep;
    assign p_above_sep = beat.pulse_length > sep;
    assign p_above_max = {1'b0, beat.pulse_length} > lmax;
    assign pair_ok     = !(p_above_sep || p_below_min);

    always_comb
    begin
        phase_next       = phase_reg;
        current_bit_next = current_bit_reg;
        shift_byte_next  = shift_byte_reg;
        bit_count_next   = bit_count_reg;
        byte_count_next  = byte_count_reg;
        pulse_count_next = pulse_count_reg;
        run_data   = 1'b0;
        run_group  = 1'b0;
        fin        = 1'b0;
        fin_status = mpd_pkg::ST_OK;
        has_result = 1'b0;
        result     = '0;
        pushed     = '0;
        pulse_sum  = '0;

        case (phase_reg)
            PH_DRAIN:
            begin
                if (last)
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_IDLE:
            begin
                current_bit_next = cfg.first_bit;
                shift_byte_next  = '0;
                bit_count_next   = '0;
                byte_count_next  = '0;
                pulse_count_next = '0;
                if (cfg.clock_aligned)
                begin
                    if (!pair_ok)
                    begin
                        fin        = 1'b1;
                        fin_status = mpd_pkg::ST_ALIGN;
                    end
                    else
                    begin
                        shift_byte_next = push_bit(8'd0, cfg.first_bit, cfg.msb_first);
                        bit_count_next  = 3'd1;
                        if (last)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                else
                begin
                    shift_byte_next = push_bit(8'd0, cfg.first_bit, cfg.msb_first);
                    bit_count_next  = 3'd1;
                    phase_next      = PH_DATA;
                    run_data        = 1'b1;
                end
            end
            PH_PAIR:
            begin
                if (!pair_ok)
                begin
                    fin        = 1'b1;
                    fin_status = mpd_pkg::ST_RANGE;
                end
                else
                begin
                    pulse_sum        = {1'b0, pulse_count_next} + 17'd2;
                    pulse_count_next = pulse_sum[16] ? 16'hFFFF : pulse_sum[15:0];
                    phase_next       = PH_DATA;
                    run_group        = 1'b1;
                end
            end
            default:
            begin
                run_data = 1'b1;
            end
        endcase

        if (run_data)
        begin
            if (p_below_sep)
            begin
                if (p_below_min)
                begin
                    fin        = 1'b1;
                    fin_status = mpd_pkg::ST_RANGE;
                end
                else if (last)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    phase_next = PH_PAIR;
                end
            end
            else if (p_above_max)
            begin
                fin        = 1'b1;
                fin_status = mpd_pkg::ST_RANGE;
            end
            else
            begin
                current_bit_next = ~current_bit_next;
                pulse_sum        = {1'b0, pulse_count_next} + 17'd1;
                pulse_count_next = pulse_sum[16] ? 16'hFFFF : pulse_sum[15:0];
                phase_next       = PH_DATA;
                run_group        = 1'b1;
            end
        end

        if (run_group)
        begin
            if (last)
            begin
                fin = 1'b1;
            end
            else
            begin
                pushed = push_bit(shift_byte_next, current_bit_next, cfg.msb_first);
                if (bit_count_next == 3'd7)
                begin
                    has_result          = 1'b1;
                    result.data_byte    = pushed;
                    result.bits_in_byte = 4'd8;
                    result.status       = mpd_pkg::ST_OK;
                    if ({1'b0, byte_count_next} + 9'd1 == {1'b0, cfg.max_bytes})
                    begin
                        result.result_kind = mpd_pkg::KIND_SUMMARY;
                        result.total_bits  = {cfg.max_bytes, 3'b000};
                        shift_byte_next    = pushed;
                        phase_next         = PH_DRAIN;
                    end
                    else
                    begin
                        byte_count_next    = byte_count_next + 8'd1;
                        result.result_kind = mpd_pkg::KIND_DATA;
                        result.total_bits  = {byte_count_next, 3'b000};
                        shift_byte_next    = '0;
                        bit_count_next     = '0;
                    end
                end
                else
                begin
                    shift_byte_next = pushed;
                    bit_count_next  = bit_count_next + 3'd1;
                end
            end
        end

        if (fin)
        begin
            has_result          = 1'b1;
            result.result_kind  = mpd_pkg::KIND_SUMMARY;
            result.data_byte    = shift_byte_next;
            result.bits_in_byte = {1'b0, bit_count_next};
            result.total_bits   = {byte_count_next, bit_count_next};
            result.status       = fin_status;
            phase_next          = last ? PH_IDLE : PH_DRAIN;
        end

        result.pulses_used = pulse_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            current_bit_reg <= 1'b0;
            shift_byte_reg  <= '0;
            bit_count_reg   <= '0;
            byte_count_reg  <= '0;
            pulse_count_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg       <= phase_next;
            current_bit_reg <= current_bit_next;
            shift_byte_reg  <= shift_byte_next;
            bit_count_reg   <= bit_count_next;
            byte_count_reg  <= byte_count_next;
            pulse_count_reg <= pulse_count_next;
        end
    end

`ifndef SYNTHESIS
    a_data_full_ok: assert property (@(posedge clk) disable iff (!rst_n)
        has_result && result.result_kind == mpd_pkg::KIND_DATA
            |-> result.bits_in_byte == 4'd8 && result.status == mpd_pkg::ST_OK)
        else $error("data beat without full byte or with nonzero status");

    a_drain_silent: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg == PH_DRAIN |-> !has_result)
        else $error("result produced while draining frame");

    a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        has_result |-> result.bits_in_byte <= 4'd8)
        else $error("bits_in_byte beyond a byte");

    a_drain_holds: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg == PH_DRAIN && !last |=> phase_reg == PH_DRAIN)
        else $error("drain left before last pulse");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/manchester_pulse_decoder.sv @@
// Channel  | Signals                          | Beat
// ---------+----------------------------------+-------------------------------
// in       | in_valid, in_ready, in_data      | one pulse length and marker
// out      | out_valid, out_ready, out_data   | one data byte or frame summary
// cfg      | cfg_write, cfg_index, cfg_data   | one register write, no wait
//
// One pulse per cycle while the output is not held: a pulse is registered at the
// input, decoded in one pass through the classifier and bit packer, and any
// result lands in the output register on the next edge, raising out_valid.
// A held output stalls decoding of the registered pulse, and in_ready then
// drops once that register is occupied. Reset clears all control state and
// loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module manchester_pulse_decoder (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire mpd_pkg::in_t                      in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output mpd_pkg::out_t                          out_data,
    input  wire logic                              cfg_write,
    input  wire logic [mpd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [mpd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    mpd_pkg::cfg_t cfg;
    mpd_pkg::in_t  in_data_reg;
    mpd_pkg::out_t out_data_reg;
    mpd_pkg::out_t step_result;
    logic          in_valid_reg;
    logic          out_valid_reg;
    logic          step;
    logic          step_has_result;

    mpd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    mpd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .fire       (step),
        .beat       (in_data_reg),
        .has_result (step_has_result),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step && step_has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_data_reg <= in_data;
        end
        if (step && step_has_result)
        begin
            out_data_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> !(out_valid_reg && !out_ready))
        else $error("decode step while output beat is held");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step |=> in_valid_reg && $stable(in_data_reg))
        else $error("registered pulse lost during stall");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ready)
        else $error("input blocked with empty input register");
`endif

endmodule

`default_nettype wire
